// ----- rtl/core/byte_pattern_search_unit_macros.svh -----
// assertion macros shared by the checker
`ifndef BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bps_pkg.sv -----
package bps_pkg;

	localparam int MAX_NEEDLE_DEF   = 16;
	localparam int MAX_HAYSTACK_DEF = 65536;
	localparam int NEEDLE_BYTES     = 16;
	localparam int CFG_W            = 64;
	localparam int NLEN_W           = 5;
	localparam int OFF_W            = 18;

	typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;

	typedef enum logic [1:0] {
		CFG_NEEDLE_LOW      = 2'd0,
		CFG_NEEDLE_HIGH     = 2'd1,
		CFG_NEEDLE_LENGTH   = 2'd2,
		CFG_SEARCH_FROM_END = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic step;
		logic clear;
	} cell_ctl_t;

endpackage

// ----- rtl/core/bps_cell.sv -----
module bps_cell import bps_pkg::*; #(
	parameter int K = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [7:0]        data_byte,
	input  needle_t           needle,
	input  logic [NLEN_W-1:0] len,
	input  logic [NLEN_W-1:0] pos_lo,
	input  logic              live_in,
	output logic              live_q,
	output logic              live_d,
	output logic              mask_d
);

	localparam logic [NLEN_W-1:0] KV = NLEN_W'(K);
	localparam logic [NLEN_W-1:0] EV = NLEN_W'(K + 1);

	logic              mask_q;
	logic              early;
	logic [NLEN_W-1:0] idx;
	logic              miss;

	// candidate that has matched needle bytes 0..K
	assign live_d = live_in && (data_byte == needle[K]) && (KV < len);

	// first e haystack bytes against the last e needle bytes, e = K+1
	assign early  = pos_lo < EV;
	assign idx    = len + pos_lo - EV;
	assign miss   = early && (EV < len) && (data_byte != needle[idx[3:0]]);
	assign mask_d = mask_q && !miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			mask_q <= 1'b1;
		end else if (ctl.clear) begin
			live_q <= 1'b0;
			mask_q <= 1'b1;
		end else if (ctl.step) begin
			live_q <= live_d;
			mask_q <= mask_d;
		end
	end

endmodule

// ----- rtl/core/bps_result.sv -----
module bps_result import bps_pkg::*; #(
	parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
	parameter int MAX_HAYSTACK = MAX_HAYSTACK_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	output logic                                  load_ok,
	input  logic [$clog2(MAX_NEEDLE+1)-1:0]       len,
	input  logic                                  mode,
	input  logic [$clog2(MAX_HAYSTACK+1)-1:0]     count,
	input  logic [MAX_NEEDLE-1:0]                 live,
	input  logic [MAX_NEEDLE-1:0]                 mask,
	input  logic                                  first_vld,
	input  logic [$clog2(MAX_HAYSTACK+1)-1:0]     first_start,
	input  logic                                  last_vld,
	input  logic [$clog2(MAX_HAYSTACK+1)-1:0]     last_start,
	input  logic                                  ovf,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic signed [OFF_W-1:0]               match_offset,
	output logic                                  too_long
);

	localparam int CNT_W = $clog2(MAX_HAYSTACK+1);
	localparam int LEN_W = $clog2(MAX_NEEDLE+1);

	logic                  vld_s1;
	logic [LEN_W-1:0]      len_s1;
	logic                  mode_s1;
	logic [CNT_W-1:0]      count_s1;
	logic [MAX_NEEDLE-1:0] live_s1;
	logic [MAX_NEEDLE-1:0] mask_s1;
	logic                  first_vld_s1;
	logic [CNT_W-1:0]      first_start_s1;
	logic                  last_vld_s1;
	logic [CNT_W-1:0]      last_start_s1;
	logic                  ovf_s1;

	logic                  vld_s2;
	logic                  found_s2;
	logic [OFF_W-1:0]      off_s2;
	logic                  too_long_s2;

	logic                  adv;
	logic                  fwd_hit;
	logic [LEN_W-1:0]      fwd_k;
	logic                  rev_hit;
	logic [LEN_W-1:0]      rev_e;
	logic                  found_c;
	logic [OFF_W-1:0]      off_c;

	assign adv     = !vld_s2 || out_ready;
	assign load_ok = !vld_s1 || adv;

	// largest partial prefix at the tail, largest suffix-prefix overlap
	always_comb begin
		fwd_hit = 1'b0;
		fwd_k   = '0;
		rev_hit = 1'b0;
		rev_e   = '0;
		for (int k = 1; k < MAX_NEEDLE; k++) begin
			if ((LEN_W'(k) < len_s1) && live_s1[k-1]) begin
				fwd_hit = 1'b1;
				fwd_k   = LEN_W'(k);
			end
			if ((LEN_W'(k) < len_s1) && (CNT_W'(k) <= count_s1) && mask_s1[k-1]) begin
				rev_hit = 1'b1;
				rev_e   = LEN_W'(k);
			end
		end
	end

	always_comb begin
		found_c = 1'b0;
		off_c   = '0;
		if (len_s1 == '0) begin
			found_c = 1'b1;
			off_c   = mode_s1 ? OFF_W'(count_s1) : '0;
		end else if (!mode_s1) begin
			if (first_vld_s1) begin
				found_c = 1'b1;
				off_c   = OFF_W'(first_start_s1);
			end else if (fwd_hit) begin
				found_c = 1'b1;
				off_c   = OFF_W'(count_s1) - OFF_W'(fwd_k);
			end
		end else begin
			if (last_vld_s1) begin
				found_c = 1'b1;
				off_c   = OFF_W'(last_start_s1);
			end else if (rev_hit) begin
				found_c = 1'b1;
				off_c   = OFF_W'(rev_e) - OFF_W'(len_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_ok) begin
				vld_s1 <= load;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			len_s1         <= len;
			mode_s1        <= mode;
			count_s1       <= count;
			live_s1        <= live;
			mask_s1        <= mask;
			first_vld_s1   <= first_vld;
			first_start_s1 <= first_start;
			last_vld_s1    <= last_vld;
			last_start_s1  <= last_start;
			ovf_s1         <= ovf;
		end
		if (adv && vld_s1) begin
			found_s2    <= found_c;
			off_s2      <= off_c;
			too_long_s2 <= ovf_s1;
		end
	end

	assign out_valid    = vld_s2;
	assign found        = found_s2;
	assign match_offset = off_s2;
	assign too_long     = too_long_s2;

endmodule

// ----- rtl/core/byte_pattern_search_unit.sv -----
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
// in       | in_valid / in_ready    | data_byte, last_byte
// out      | out_valid / out_ready  | found, match_offset, too_long
//
// one haystack byte per cycle while in_ready is high; a row of MAX_NEEDLE compare cells updates all
// candidate starts in the cycle the byte transaction is taken
// after the last byte the result passes through one snapshot stage, then
// the priority pick and offset arithmetic into the output register
// arst_n clears needle registers, cells and the valid flags of both result stages
// out_ready low holds the result; once the snapshot stage is also full,
// in_ready drops until the output moves
module byte_pattern_search_unit import bps_pkg::*; #(
	parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
	parameter int MAX_HAYSTACK = MAX_HAYSTACK_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cfg_reg_e                cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              data_byte,
	input  logic                    last_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic signed [OFF_W-1:0] match_offset,
	output logic                    too_long
);

	localparam int CNT_W = $clog2(MAX_HAYSTACK+1);
	localparam int LEN_W = $clog2(MAX_NEEDLE+1);

	needle_t               needle_q;
	logic [NLEN_W-1:0]     needle_length_q;
	logic                  mode_q;

	logic [CNT_W-1:0]      count_q;
	logic                  first_vld_q;
	logic [CNT_W-1:0]      first_start_q;
	logic                  last_vld_q;
	logic [CNT_W-1:0]      last_start_q;
	logic                  ovf_q;

	logic [LEN_W-1:0]      len_used;
	logic [NLEN_W-1:0]     len_cell;
	logic [NLEN_W-1:0]     pos_lo;
	logic                  in_acc;
	logic                  step;
	logic                  done;
	cell_ctl_t             ctl;

	logic [MAX_NEEDLE-1:0] live_q;
	logic [MAX_NEEDLE-1:0] live_d;
	logic [MAX_NEEDLE-1:0] mask_d;
	logic                  full_d;
	logic [CNT_W-1:0]      start_d;

	logic [CNT_W-1:0]      count_d;
	logic                  first_vld_d;
	logic [CNT_W-1:0]      first_start_d;
	logic                  last_vld_d;
	logic [CNT_W-1:0]      last_start_d;
	logic                  ovf_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q        <= '0;
			needle_length_q <= '0;
			mode_q          <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NEEDLE_LOW:      needle_q[7:0]   <= cfg_data;
				CFG_NEEDLE_HIGH:     needle_q[15:8]  <= cfg_data;
				CFG_NEEDLE_LENGTH:   needle_length_q <= cfg_data[NLEN_W-1:0];
				CFG_SEARCH_FROM_END: mode_q          <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign len_used = (needle_length_q > NLEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
	                                                          : needle_length_q[LEN_W-1:0];
	assign len_cell = NLEN_W'(len_used);
	assign pos_lo   = (count_q >= CNT_W'(NEEDLE_BYTES)) ? NLEN_W'(NEEDLE_BYTES)
	                                                    : count_q[NLEN_W-1:0];

	assign in_acc    = in_valid && in_ready;
	assign step      = in_acc && (count_q != CNT_W'(MAX_HAYSTACK));
	assign done      = in_acc && last_byte;
	assign ctl.step  = step;
	assign ctl.clear = done;

	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		bps_cell #(
			.K(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.data_byte(data_byte),
			.needle   (needle_q),
			.len      (len_cell),
			.pos_lo   (pos_lo),
			.live_in  ((k == 0) ? 1'b1 : live_q[(k == 0) ? 0 : k-1]),
			.live_q   (live_q[k]),
			.live_d   (live_d[k]),
			.mask_d   (mask_d[k])
		);
	end

	always_comb begin
		full_d = 1'b0;
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			if (live_d[k] && (LEN_W'(k + 1) == len_used)) begin
				full_d = 1'b1;
			end
		end
	end

	assign start_d = count_q + CNT_W'(1) - CNT_W'(len_used);

	always_comb begin
		count_d       = count_q;
		first_vld_d   = first_vld_q;
		first_start_d = first_start_q;
		last_vld_d    = last_vld_q;
		last_start_d  = last_start_q;
		ovf_d         = ovf_q;
		if (step) begin
			count_d = count_q + CNT_W'(1);
			if (full_d) begin
				if (!first_vld_q) begin
					first_vld_d   = 1'b1;
					first_start_d = start_d;
				end
				last_vld_d   = 1'b1;
				last_start_d = start_d;
			end
		end else if (in_acc) begin
			ovf_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			first_vld_q   <= 1'b0;
			first_start_q <= '0;
			last_vld_q    <= 1'b0;
			last_start_q  <= '0;
			ovf_q         <= 1'b0;
		end else if (done) begin
			count_q       <= '0;
			first_vld_q   <= 1'b0;
			first_start_q <= '0;
			last_vld_q    <= 1'b0;
			last_start_q  <= '0;
			ovf_q         <= 1'b0;
		end else begin
			count_q       <= count_d;
			first_vld_q   <= first_vld_d;
			first_start_q <= first_start_d;
			last_vld_q    <= last_vld_d;
			last_start_q  <= last_start_d;
			ovf_q         <= ovf_d;
		end
	end

	bps_result #(
		.MAX_NEEDLE  (MAX_NEEDLE),
		.MAX_HAYSTACK(MAX_HAYSTACK)
	) u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (done),
		.load_ok     (in_ready),
		.len         (len_used),
		.mode        (mode_q),
		.count       (count_d),
		.live        (live_d & {MAX_NEEDLE{step}} | live_q & {MAX_NEEDLE{!step}}),
		.mask        (mask_d),
		.first_vld   (first_vld_d),
		.first_start (first_start_d),
		.last_vld    (last_vld_d),
		.last_start  (last_start_d),
		.ovf         (ovf_d),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_offset(match_offset),
		.too_long    (too_long)
	);

endmodule

// ----- rtl/core/bps_checker.sv -----
`include "byte_pattern_search_unit_macros.svh"

module bps_checker import bps_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    found,
	input logic signed [OFF_W-1:0] match_offset
);

	`BPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result transaction dropped")
	`BPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(found) && $stable(match_offset), "result changed while stalled")
	`BPS_ASSERT_NOW(a_miss_zero, out_valid && !found, match_offset == '0, "miss with nonzero offset")
	`BPS_ASSERT_NOW(a_neg_overlap, out_valid && match_offset[OFF_W-1], found && (match_offset[OFF_W-1:4] == '1), "negative offset out of overlap range")
	`BPS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind byte_pattern_search_unit bps_checker u_bps_checker (.*);

// ----- sim/tb_byte_pattern_search_unit.sv -----
`timescale 1ns / 1ps

module tb_byte_pattern_search_unit;
	import bps_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 240;
	localparam int LONG_BYTES   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 6;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] offset;
		logic             too_long;
	} search_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	cfg_reg_e                cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [7:0]              data_byte;
	logic                    last_byte;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic signed [OFF_W-1:0] match_offset;
	logic                    too_long;

	// needle registers as last written
	logic [CFG_W-1:0]  nd_lo;
	logic [CFG_W-1:0]  nd_hi;
	logic [NLEN_W-1:0] nd_len;
	logic              rev_mode;

	// haystack tracking
	int          hay_count;
	logic [15:0] live;
	logic        first_ok;
	int          first_start;
	logic        last_ok;
	int          last_end;
	logic [15:0] ps_mask;
	logic        ovf;

	search_result_t pending_results[$];
	logic [7:0]     hay_buf[$];

	int   error_count;
	int   cycle_count;
	int   sender_idle_pct;
	int   sink_idle_pct;
	logic hold_req;

	byte_pattern_search_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset),
		.too_long     (too_long)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic int used_len();
		return (nd_len > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : int'(nd_len);
	endfunction

	function automatic logic [7:0] needle_at(input int k);
		logic [3:0] idx;
		idx = k[3:0];
		return idx[3] ? nd_hi[idx[2:0]*8 +: 8] : nd_lo[idx[2:0]*8 +: 8];
	endfunction

	function automatic void clear_haystack();
		hay_count   = 0;
		live        = '0;
		first_ok    = 1'b0;
		first_start = 0;
		last_ok     = 1'b0;
		last_end    = 0;
		ps_mask     = '1;
		ovf         = 1'b0;
	endfunction

	// advance the search by one haystack byte, queue the result on the last one
	function automatic void search_track_byte(input logic [7:0] b, input logic lst);
		int len;
		int pos;
		int h;
		int top;
		int off;
		logic hit;
		logic [15:0] nxt;
		search_result_t r;
		len = used_len();
		if (hay_count < MAX_HAYSTACK_DEF) begin
			pos = hay_count;
			nxt = '0;
			for (int k = 0; k < len; k++) begin
				if (((k == 0) ? 1'b1 : live[k-1]) && b == needle_at(k))
					nxt[k] = 1'b1;
			end
			live = nxt;
			if (len > 0 && nxt[len-1]) begin
				if (!first_ok) begin
					first_ok    = 1'b1;
					first_start = pos + 1 - len;
				end
				last_ok  = 1'b1;
				last_end = pos + 1;
			end
			for (int e = 1; e < len; e++) begin
				if (e > pos && ps_mask[e-1] && b != needle_at(len - e + pos))
					ps_mask[e-1] = 1'b0;
			end
			hay_count = pos + 1;
		end else begin
			ovf = 1'b1;
		end
		if (!lst)
			return;
		h = hay_count;
		hit = 1'b0;
		off = 0;
		if (len == 0) begin
			hit = 1'b1;
			off = rev_mode ? h : 0;
		end else if (!rev_mode) begin
			if (first_ok) begin
				hit = 1'b1;
				off = first_start;
			end else begin
				// tail of the haystack that is a needle prefix, longest first
				for (int k = len - 1; k > 0; k--) begin
					if (live[k-1]) begin
						hit = 1'b1;
						off = h - k;
						break;
					end
				end
			end
		end else begin
			if (last_ok) begin
				hit = 1'b1;
				off = last_end - len;
			end else begin
				top = (len - 1 < h) ? len - 1 : h;
				for (int e = top; e > 0; e--) begin
					if (ps_mask[e-1]) begin
						hit = 1'b1;
						off = e - len;
						break;
					end
				end
			end
		end
		r.found    = hit;
		r.offset   = off[OFF_W-1:0];
		r.too_long = ovf;
		pending_results.push_back(r);
		clear_haystack();
	endfunction

	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		search_result_t want;
		search_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.found    = found;
				got.offset   = match_offset;
				got.too_long = too_long;
				if (pending_results.size() == 0) begin
					if (error_count < 10)
						$display("unexpected result: found %0b offset %0d too_long %0b",
							got.found, $signed(got.offset), got.too_long);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.found !== want.found || got.offset !== want.offset ||
						got.too_long !== want.too_long) begin
						if (error_count < 10)
							$display({"mismatch: expected found %0b offset %0d too_long %0b,",
								" got found %0b offset %0d too_long %0b"},
								want.found, $signed(want.offset), want.too_long,
								got.found, $signed(got.offset), got.too_long);
						error_count++;
					end
				end
			end
		end
	end

	task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NEEDLE_LOW:      nd_lo = val;
			CFG_NEEDLE_HIGH:     nd_hi = val;
			CFG_NEEDLE_LENGTH:   nd_len = val[NLEN_W-1:0];
			CFG_SEARCH_FROM_END: rev_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
		input logic [CFG_W-1:0] len_word, input logic [CFG_W-1:0] mode_word);
		write_reg(CFG_NEEDLE_LOW, lo);
		write_reg(CFG_NEEDLE_HIGH, hi);
		write_reg(CFG_NEEDLE_LENGTH, len_word);
		write_reg(CFG_SEARCH_FROM_END, mode_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		search_track_byte(b, lst);
	endtask

	task automatic send_haystack();
		foreach (hay_buf[i])
			push_byte(hay_buf[i], i == hay_buf.size() - 1);
	endtask

	// sender pauses until every result is back
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mix of needle fragments, stray needle bytes and noise, cut to the target size
	task automatic make_haystack(input int target, input bit noisy);
		int len;
		int pick;
		int cut;
		len = used_len();
		hay_buf.delete();
		while (hay_buf.size() < target) begin
			pick = $urandom_range(9);
			if (noisy || len == 0 || pick < 2) begin
				hay_buf.push_back(8'($urandom_range(255)));
			end else if (pick < 4) begin
				hay_buf.push_back(needle_at($urandom_range(len - 1)));
			end else if (pick < 7) begin
				for (int k = 0; k < len; k++)
					hay_buf.push_back(needle_at(k));
			end else if (pick < 9) begin
				cut = $urandom_range(len, 1);
				for (int k = 0; k < cut; k++)
					hay_buf.push_back(needle_at(k));
			end else begin
				cut = $urandom_range(len, 1);
				for (int k = len - cut; k < len; k++)
					hay_buf.push_back(needle_at(k));
			end
		end
		while (hay_buf.size() > target)
			void'(hay_buf.pop_back());
	endtask

	task automatic random_needle();
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [CFG_W-1:0] len_word;
		logic [CFG_W-1:0] mode_word;
		logic [7:0] sym_a;
		logic [7:0] sym_b;
		int pick;
		sym_a = 8'($urandom);
		sym_b = 8'($urandom);
		if ($urandom_range(9) < 7) begin
			for (int i = 0; i < 8; i++) begin
				lo[i*8 +: 8] = $urandom_range(1) ? sym_a : sym_b;
				hi[i*8 +: 8] = $urandom_range(1) ? sym_a : sym_b;
			end
		end else begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
		end
		len_word  = ($urandom_range(9) < 3) ? {$urandom, $urandom} : '0;
		mode_word = ($urandom_range(9) < 3) ? {$urandom, $urandom} : '0;
		pick = $urandom_range(19);
		if (pick == 0)
			len_word[NLEN_W-1:0] = '0;
		else if (pick < 3)
			len_word[NLEN_W-1:0] = NLEN_W'(16);
		else if (pick == 3)
			len_word[NLEN_W-1:0] = NLEN_W'($urandom_range(31, 17));
		else
			len_word[NLEN_W-1:0] = NLEN_W'($urandom_range(6, 1));
		mode_word[0] = 1'($urandom_range(1));
		set_config(lo, hi, len_word, mode_word);
	endtask

	task automatic test_directed();
		// reset defaults: empty needle, forward
		hay_buf = {8'h00};
		send_haystack();
		wait_results_done();
		// empty needle, reverse gives the haystack length
		set_config('1, '0, 64'd0, 64'd1);
		hay_buf = {8'hff, 8'hff, 8'hff};
		send_haystack();
		wait_results_done();
		// needle "abc", forward: full match, then tail prefix only
		set_config(64'h636261, '1, 64'd3, 64'd0);
		hay_buf = {8'h7a, 8'h61, 8'h62, 8'h63};
		send_haystack();
		hay_buf = {8'h7a, 8'h61, 8'h62};
		send_haystack();
		wait_results_done();
		// reverse: haystack head equals needle tail, then no match at all
		set_config(64'h636261, '0, 64'd3, 64'd1);
		hay_buf = {8'h62, 8'h63, 8'h61, 8'h62};
		send_haystack();
		hay_buf = {8'h7a, 8'h7a};
		send_haystack();
		wait_results_done();
		// oversized length saturates to a full 16 byte needle
		set_config(64'h0, '1, 64'd31, 64'd0);
		hay_buf = {8'h00, 8'h00, 8'h00};
		send_haystack();
		wait_results_done();
	endtask

	task automatic test_long_haystack();
		int n;
		sender_idle_pct = 0;
		sink_idle_pct   = 0;
		// long haystack with no idling, empty needle in reverse reports its length
		set_config('0, '0, 64'd0, 64'd1);
		n = LONG_BYTES;
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom), i == n - 1);
		wait_results_done();
		// long haystack of two needle symbols against a two byte needle
		set_config({$urandom, $urandom}, '0, 64'd2, {63'd0, 1'($urandom_range(1))});
		n = LONG_BYTES;
		for (int i = 0; i < n; i++)
			push_byte($urandom_range(1) ? nd_lo[7:0] : nd_lo[15:8], i == n - 1);
		wait_results_done();
		sender_idle_pct = 27;
		sink_idle_pct   = 27;
	endtask

	task automatic test_output_stall();
		sender_idle_pct = 0;
		set_config(64'h5aa5, '0, 64'd2, 64'd0);
		hold_req = 1'b1;
		repeat (24) begin
			make_haystack($urandom_range(3, 1), 1'b0);
			send_haystack();
		end
		in_valid <= 1'b0;
		while (hold_req)
			@(posedge clk);
		wait_results_done();
		sender_idle_pct = 27;
	endtask

	task automatic test_random();
		int sent;
		int target;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			random_needle();
			repeat ($urandom_range(8, 3)) begin
				target = ($urandom_range(9) == 0) ? $urandom_range(40, 17) :
					$urandom_range(12, 1);
				make_haystack(target, $urandom_range(9) < 2);
				send_haystack();
				sent += hay_buf.size();
			end
			wait_results_done();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_NEEDLE_LOW;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		nd_lo     = '0;
		nd_hi     = '0;
		nd_len    = '0;
		rev_mode  = 1'b0;
		clear_haystack();
		error_count     = 0;
		hold_req        = 1'b0;
		sender_idle_pct = 27;
		sink_idle_pct   = 27;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_haystack();
		test_output_stall();
		test_random();
		wait_results_done();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_cell.sv
rtl/core/bps_result.sv
rtl/core/byte_pattern_search_unit.sv
rtl/core/bps_checker.sv
sim/tb_byte_pattern_search_unit.sv
